// ===== hdl/rect_circle_overlap_test_defines.svh =====
// assertion macros for the overlap test block
`ifndef RECT_CIRCLE_OVERLAP_TEST_DEFINES_SVH
`define RECT_CIRCLE_OVERLAP_TEST_DEFINES_SVH

`ifndef SYNTH
`define RCO_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RCO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RCO_ASSERT_SAME(label, ante, cons, msg)
`define RCO_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/rco_pkg.sv =====
package rco_pkg;

	localparam int COORD_BITS = 16;
	localparam int LANES      = 4;
	localparam int STAGES     = 6;

	localparam int DIFF_W   = COORD_BITS + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int SQ_W     = 2 * COORD_BITS;
	localparam int EE_W     = SQ_W + 1;
	localparam int MAG_W    = PROD_W - 1;
	localparam int MAG_HI_W = MAG_W / 2;
	localparam int MAG_LO_W = MAG_W - MAG_HI_W;
	localparam int EE_HI_W  = EE_W / 2;
	localparam int EE_LO_W  = EE_W - EE_HI_W;
	localparam int RAD_W    = COORD_BITS - 1;
	localparam int RAD2_W   = 2 * RAD_W;
	localparam int C2_W     = 2 * MAG_W;

	typedef enum logic [1:0] {
		HIT_NONE   = 2'd0,
		HIT_CORNER = 2'd1,
		HIT_EDGE   = 2'd2,
		HIT_INSIDE = 2'd3
	} hit_kind_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	typedef struct packed {
		logic corner_lt;
		logic t_le0;
		logic t_ge_ee;
		logic mid_lt;
		logic c_neg;
		logic c_zero;
	} lane_flags_t;

endpackage

// ===== hdl/rect_circle_overlap_test.sv =====
// depth: six register stages from input accept to out_valid
// throughput: one word per cycle while out_ready is high; each stage moves on whenever its successor has room
// every distance test runs in parallel edge lanes, one per rectangle edge, then a merge stage
// reset: arst_n low clears all stage valid flags; the pipeline comes up empty
`include "rect_circle_overlap_test_defines.svh"

module rect_circle_overlap_test (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [rco_pkg::COORD_BITS-1:0] corner0_x,
	input  logic signed [rco_pkg::COORD_BITS-1:0] corner0_y,
	input  logic signed [rco_pkg::COORD_BITS-1:0] corner1_x,
	input  logic signed [rco_pkg::COORD_BITS-1:0] corner1_y,
	input  logic signed [rco_pkg::COORD_BITS-1:0] corner2_x,
	input  logic signed [rco_pkg::COORD_BITS-1:0] corner2_y,
	input  logic signed [rco_pkg::COORD_BITS-1:0] corner3_x,
	input  logic signed [rco_pkg::COORD_BITS-1:0] corner3_y,
	input  logic signed [rco_pkg::COORD_BITS-1:0] centre_x,
	input  logic signed [rco_pkg::COORD_BITS-1:0] centre_y,
	input  logic        [rco_pkg::RAD_W-1:0]      circle_radius,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  overlaps,
	output logic        [1:0]                     hit_kind
);

	localparam int NS = rco_pkg::STAGES;

	logic [NS-1:0] stage_valid_q;
	logic [NS-1:0] stage_en;
	rco_pkg::stage_en_t en;

	// a stage loads when it is empty or its content moves on this cycle
	always_comb begin
		stage_en[NS-1] = !stage_valid_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			stage_en[k] = !stage_valid_q[k] || stage_en[k+1];
		end
	end

	assign en = '{s1: stage_en[0], s2: stage_en[1], s3: stage_en[2],
	              s4: stage_en[3], s5: stage_en[4], s6: stage_en[5]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (stage_en[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	assign in_ready  = stage_en[0];
	assign out_valid = stage_valid_q[NS-1];

	// radius squared, shared by all lanes
	logic [rco_pkg::RAD_W-1:0]  r_s1;
	logic [rco_pkg::RAD2_W-1:0] r2_s2, r2_s3;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			r_s1 <= circle_radius;
		end
		if (en.s2) begin
			r2_s2 <= rco_pkg::RAD2_W'(r_s1) * rco_pkg::RAD2_W'(r_s1);
		end
		if (en.s3) begin
			r2_s3 <= r2_s2;
		end
	end

	logic signed [rco_pkg::COORD_BITS-1:0] vx [rco_pkg::LANES];
	logic signed [rco_pkg::COORD_BITS-1:0] vy [rco_pkg::LANES];

	assign vx[0] = corner0_x;
	assign vy[0] = corner0_y;
	assign vx[1] = corner1_x;
	assign vy[1] = corner1_y;
	assign vx[2] = corner2_x;
	assign vy[2] = corner2_y;
	assign vx[3] = corner3_x;
	assign vy[3] = corner3_y;

	rco_pkg::lane_flags_t [rco_pkg::LANES-1:0] flags_s5;

	for (genvar g = 0; g < rco_pkg::LANES; g++) begin : g_lane
		localparam int NEXT = (g + 1) % rco_pkg::LANES;
		rco_lane u_lane (
			.clk      (clk),
			.en       (en),
			.ax       (vx[g]),
			.ay       (vy[g]),
			.bx       (vx[NEXT]),
			.by       (vy[NEXT]),
			.px       (centre_x),
			.py       (centre_y),
			.r2_s3    (r2_s3),
			.flags_s5 (flags_s5[g])
		);
	end

	rco_pkg::hit_kind_t kind_w;

	rco_merge u_merge (
		.clk      (clk),
		.en_s6    (en.s6),
		.flags_s5 (flags_s5),
		.overlaps (overlaps),
		.hit_kind (kind_w)
	);

	assign hit_kind = kind_w;

	`RCO_ASSERT_SAME(a_full_when_stalled, !in_ready, &stage_valid_q, "input stalled with a bubble")
	`RCO_ASSERT_SAME(a_flag_matches_kind, out_valid, overlaps == (kind_w != rco_pkg::HIT_NONE), "overlap flag disagrees with hit kind")
	`RCO_ASSERT_NEXT(a_mid_stage_holds, stage_valid_q[2] && !stage_en[2], stage_valid_q[2], "stalled stage lost its word")

endmodule

// ===== hdl/rco_lane.sv =====
module rco_lane (
	input  logic                                      clk,
	input  rco_pkg::stage_en_t                        en,
	input  logic signed [rco_pkg::COORD_BITS-1:0]     ax,
	input  logic signed [rco_pkg::COORD_BITS-1:0]     ay,
	input  logic signed [rco_pkg::COORD_BITS-1:0]     bx,
	input  logic signed [rco_pkg::COORD_BITS-1:0]     by,
	input  logic signed [rco_pkg::COORD_BITS-1:0]     px,
	input  logic signed [rco_pkg::COORD_BITS-1:0]     py,
	input  logic        [rco_pkg::RAD2_W-1:0]         r2_s3,
	output rco_pkg::lane_flags_t                      flags_s5
);

	localparam int DW   = rco_pkg::DIFF_W;
	localparam int PW   = rco_pkg::PROD_W;
	localparam int SQW  = rco_pkg::SQ_W;
	localparam int EEW  = rco_pkg::EE_W;
	localparam int MHW  = rco_pkg::MAG_HI_W;
	localparam int MLW  = rco_pkg::MAG_LO_W;
	localparam int EHW  = rco_pkg::EE_HI_W;
	localparam int ELW  = rco_pkg::EE_LO_W;
	localparam int R2W  = rco_pkg::RAD2_W;
	localparam int C2W  = rco_pkg::C2_W;
	localparam int HH_W = 2 * MHW;
	localparam int HL_W = MHW + MLW;
	localparam int LL_W = 2 * MLW;
	localparam int RH_W = R2W + EHW;
	localparam int RL_W = R2W + ELW;

	function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		smul = PW'(a) * PW'(b);
	endfunction

	// stage 1: edge vector and offset of the centre from the edge start
	logic signed [DW-1:0] ex_s1, ey_s1, dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ex_s1 <= DW'(bx) - DW'(ax);
			ey_s1 <= DW'(by) - DW'(ay);
			dx_s1 <= DW'(px) - DW'(ax);
			dy_s1 <= DW'(py) - DW'(ay);
		end
	end

	// stage 2: products
	logic signed [PW-1:0] m_exex, m_eyey, m_dxdx, m_dydy;
	logic signed [PW-1:0] p_dxex_s2, p_dyey_s2, p_exdy_s2, p_eydx_s2;
	logic        [SQW-1:0] sq_ex_s2, sq_ey_s2, sq_dx_s2, sq_dy_s2;

	assign m_exex = smul(ex_s1, ex_s1);
	assign m_eyey = smul(ey_s1, ey_s1);
	assign m_dxdx = smul(dx_s1, dx_s1);
	assign m_dydy = smul(dy_s1, dy_s1);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_dxex_s2 <= smul(dx_s1, ex_s1);
			p_dyey_s2 <= smul(dy_s1, ey_s1);
			p_exdy_s2 <= smul(ex_s1, dy_s1);
			p_eydx_s2 <= smul(ey_s1, dx_s1);
			sq_ex_s2  <= m_exex[SQW-1:0];
			sq_ey_s2  <= m_eyey[SQW-1:0];
			sq_dx_s2  <= m_dxdx[SQW-1:0];
			sq_dy_s2  <= m_dydy[SQW-1:0];
		end
	end

	// stage 3: projection, cross product, squared lengths
	logic signed [PW-1:0]  t_s3, c_s3;
	logic        [EEW-1:0] ee_s3, dd_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			t_s3  <= p_dxex_s2 + p_dyey_s2;
			c_s3  <= p_exdy_s2 - p_eydx_s2;
			ee_s3 <= EEW'(sq_ex_s2) + EEW'(sq_ey_s2);
			dd_s3 <= EEW'(sq_dx_s2) + EEW'(sq_dy_s2);
		end
	end

	// stage 4: split the wide squares into partial products and register the corner, projection and side flags
	logic        [PW-1:0]  c_abs;
	logic        [MHW-1:0] mag_hi;
	logic        [MLW-1:0] mag_lo;
	logic signed [PW-1:0]  ee_sx;

	assign c_abs  = c_s3[PW-1] ? -c_s3 : c_s3;
	assign mag_hi = c_abs[MHW+MLW-1:MLW];
	assign mag_lo = c_abs[MLW-1:0];
	assign ee_sx  = signed'(PW'(ee_s3));

	logic [HH_W-1:0] hh_s4;
	logic [HL_W-1:0] hl_s4;
	logic [LL_W-1:0] ll_s4;
	logic [RH_W-1:0] re_hi_s4;
	logic [RL_W-1:0] re_lo_s4;
	logic            corner_lt_s4, t_le0_s4, t_ge_ee_s4, c_neg_s4, c_zero_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			hh_s4        <= HH_W'(mag_hi) * HH_W'(mag_hi);
			hl_s4        <= HL_W'(mag_hi) * HL_W'(mag_lo);
			ll_s4        <= LL_W'(mag_lo) * LL_W'(mag_lo);
			re_hi_s4     <= RH_W'(r2_s3) * RH_W'(ee_s3[EEW-1:ELW]);
			re_lo_s4     <= RL_W'(r2_s3) * RL_W'(ee_s3[ELW-1:0]);
			corner_lt_s4 <= dd_s3 < EEW'(r2_s3);
			t_le0_s4     <= t_s3[PW-1] | (t_s3 == '0);
			t_ge_ee_s4   <= !(t_s3 < ee_sx);
			c_neg_s4     <= c_s3[PW-1];
			c_zero_s4    <= (c_s3 == '0);
		end
	end

	// stage 5: cross squared against radius squared times edge length squared
	logic [C2W-1:0] c2, re;

	assign c2 = (C2W'(hh_s4) << (2 * MLW)) + (C2W'(hl_s4) << (MLW + 1)) + C2W'(ll_s4);
	assign re = (C2W'(re_hi_s4) << ELW) + C2W'(re_lo_s4);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			flags_s5.corner_lt <= corner_lt_s4;
			flags_s5.t_le0     <= t_le0_s4;
			flags_s5.t_ge_ee   <= t_ge_ee_s4;
			flags_s5.mid_lt    <= c2 < re;
			flags_s5.c_neg     <= c_neg_s4;
			flags_s5.c_zero    <= c_zero_s4;
		end
	end

endmodule

// ===== hdl/rco_merge.sv =====
module rco_merge (
	input  logic                                         clk,
	input  logic                                         en_s6,
	input  rco_pkg::lane_flags_t [rco_pkg::LANES-1:0]    flags_s5,
	output logic                                         overlaps,
	output rco_pkg::hit_kind_t                           hit_kind
);

	logic [rco_pkg::LANES-1:0] corner_hit, edge_hit, neg_side, pos_side;

	for (genvar g = 0; g < rco_pkg::LANES; g++) begin : g_edge
		localparam int NEXT = (g + 1) % rco_pkg::LANES;
		assign corner_hit[g] = flags_s5[g].corner_lt;
		// clamp the projection to the nearer end when it falls off the segment
		assign edge_hit[g] = flags_s5[g].t_le0   ? flags_s5[g].corner_lt :
		                     flags_s5[g].t_ge_ee ? flags_s5[NEXT].corner_lt :
		                     flags_s5[g].mid_lt;
		assign neg_side[g] = flags_s5[g].c_neg;
		assign pos_side[g] = !flags_s5[g].c_neg && !flags_s5[g].c_zero;
	end

	rco_pkg::hit_kind_t kind;

	always_comb begin
		if (|corner_hit) begin
			kind = rco_pkg::HIT_CORNER;
		end else if (|edge_hit) begin
			kind = rco_pkg::HIT_EDGE;
		end else if ((&neg_side) || (&pos_side)) begin
			kind = rco_pkg::HIT_INSIDE;
		end else begin
			kind = rco_pkg::HIT_NONE;
		end
	end

	logic               overlaps_q;
	rco_pkg::hit_kind_t hit_kind_q;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			overlaps_q <= (kind != rco_pkg::HIT_NONE);
			hit_kind_q <= kind;
		end
	end

	assign overlaps = overlaps_q;
	assign hit_kind = hit_kind_q;

endmodule
